>>> rtl/core/blpe_pkg.sv
package blpe_pkg;

  // Coordinate and result widths.
  localparam int unsigned COORD_W = 9;
  localparam int unsigned PAGE_W  = 2;
  localparam int unsigned ERR_W   = 11;
  localparam int unsigned ADDR_W  = 15;
  localparam int unsigned MASK_W  = 8;

  // Frame store row geometry: one row is LINE_BYTES bytes of eight pixels each.
  localparam int unsigned LINE_BYTES = 32;
  localparam int unsigned LINE_SHIFT = 5;
  localparam int unsigned BYTE_SHIFT = 3;
  localparam int unsigned COL_W      = COORD_W - BYTE_SHIFT;

  // Packed field widths on the streams.
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 24;

  // Leftmost pixel of a byte sits in the most significant bit.
  localparam logic [MASK_W-1:0] MASK_MSB = 8'h80;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } blpe_req_e;

  // Pixel handed from the line walker to the address unit.
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PAGE_W-1:0]  page;
    logic               last;
  } blpe_pixel_t;

endpackage

>>> rtl/core/bresenham_line_pixel_engine.sv
// An accepted item waits in the input stage until the walker executes it; its pixel
// transaction is then registered in the output register and offered on the master side.
// Throughput: one item per cycle while the pixel stream is not stalled; the input stage
// and the output register let a new item enter while a finished pixel waits to be taken.
// Reset (rst_ni low, asynchronous) empties both stages and clears the line state,
// so the engine comes up idle and ignores step items until a start item arrives.
module bresenham_line_pixel_engine #(
  parameter int unsigned PAGE_BYTES = 8192
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request stream.
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata from bit 0: x_start[8:0], y_start[17:9], x_end[26:18], y_end[35:27],
  // page_sel[37:36], zero fill [39:38].
  input  logic [blpe_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // tuser: req_type (0 start a line, 1 emit the next pixel).
  input  logic                             s_axis_tuser_i,
  // Pixel stream.
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata from bit 0: byte_address[14:0], bit_mask[22:15], write_enable[23].
  output logic [blpe_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // tlast: set on the final pixel of the line.
  output logic                             m_axis_tlast_o
);
  import blpe_pkg::*;

  // Input stage: holds one accepted request until the walker executes it.
  logic                  in_valid_q, in_valid_d;
  blpe_req_e             in_req_q;
  logic [COORD_W-1:0]    in_xs_q, in_ys_q, in_xe_q, in_ye_q;
  logic [PAGE_W-1:0]     in_page_q;

  // Output register: one finished pixel transaction.
  logic                  out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]     out_addr_q;
  logic [MASK_W-1:0]     out_mask_q;
  logic                  out_we_q;
  logic                  out_last_q;

  logic                  s_accept;
  logic                  advance;
  logic                  out_load;
  blpe_pixel_t           pixel;
  logic [ADDR_W-1:0]     pix_addr;
  logic [MASK_W-1:0]     pix_mask;
  logic                  pix_we;

  // The held request executes whenever the output register is free or being
  // drained in this cycle; a start request never needs the output register,
  // but keeping one rule keeps the order of transactions obvious.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = pixel.valid;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request payload, loaded with each accepted transaction.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_req_q  <= blpe_req_e'(s_axis_tuser_i);
      in_xs_q   <= s_axis_tdata_i[8:0];
      in_ys_q   <= s_axis_tdata_i[17:9];
      in_xe_q   <= s_axis_tdata_i[26:18];
      in_ye_q   <= s_axis_tdata_i[35:27];
      in_page_q <= s_axis_tdata_i[37:36];
    end
  end

  // The line walker keeps the Bresenham state and produces the current pixel.
  blpe_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .exec_i     (advance),
    .req_type_i (in_req_q),
    .x_start_i  (in_xs_q),
    .y_start_i  (in_ys_q),
    .x_end_i    (in_xe_q),
    .y_end_i    (in_ye_q),
    .page_sel_i (in_page_q),
    .pixel_o    (pixel)
  );

  // The address unit maps the pixel onto a frame store byte and bit.
  blpe_addr #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_addr (
    .pixel_i        (pixel),
    .byte_address_o (pix_addr),
    .bit_mask_o     (pix_mask),
    .write_enable_o (pix_we)
  );

  // Pixel payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_addr_q <= pix_addr;
      out_mask_q <= pix_mask;
      out_we_q   <= pix_we;
      out_last_q <= pixel.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_we_q, out_mask_q, out_addr_q};
  assign m_axis_tlast_o  = out_last_q;

  // A pixel transaction only appears after a request was executed.
  a_out_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance))
    else $error("pixel transaction without an executed request");

  // A waiting request stays put while the output register is stalled.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready_i) |=>
      (in_valid_q && $stable(in_req_q) && $stable(in_xs_q)))
    else $error("request lost while the output was stalled");

  // Executing a request while the output is full requires it to drain.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_valid_q) |-> m_axis_tready_i)
    else $error("pixel register overwritten before it was taken");

endmodule

>>> rtl/core/blpe_core.sv
module blpe_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          exec_i,
  input  blpe_pkg::blpe_req_e           req_type_i,
  input  logic [blpe_pkg::COORD_W-1:0]  x_start_i,
  input  logic [blpe_pkg::COORD_W-1:0]  y_start_i,
  input  logic [blpe_pkg::COORD_W-1:0]  x_end_i,
  input  logic [blpe_pkg::COORD_W-1:0]  y_end_i,
  input  logic [blpe_pkg::PAGE_W-1:0]   page_sel_i,
  output blpe_pkg::blpe_pixel_t         pixel_o
);
  import blpe_pkg::*;

  logic                     busy_q, busy_d;
  logic [COORD_W-1:0]       major_pos_q, major_pos_d;
  logic [COORD_W-1:0]       minor_pos_q, minor_pos_d;
  logic [COORD_W-1:0]       major_end_q, major_end_d;
  logic [COORD_W-1:0]       major_delta_q, major_delta_d;
  logic [COORD_W-1:0]       minor_delta_q, minor_delta_d;
  logic signed [ERR_W-1:0]  error_acc_q, error_acc_d;
  logic                     minor_down_q, minor_down_d;
  logic                     steep_q, steep_d;
  logic [PAGE_W-1:0]        page_q, page_d;

  // Start setup.
  logic [COORD_W-1:0] dx, dy;
  logic               steep_s;
  logic [COORD_W-1:0] ma0, na0, mb0, nb0;
  logic [COORD_W-1:0] ma, na, mb, nb;
  logic               swap_s;
  logic [COORD_W-1:0] s_major_delta;

  // Step.
  logic signed [ERR_W-1:0] err_sub;
  logic                    is_last;

  always_comb begin
    dx      = (x_start_i > x_end_i) ? x_start_i - x_end_i : x_end_i - x_start_i;
    dy      = (y_start_i > y_end_i) ? y_start_i - y_end_i : y_end_i - y_start_i;
    steep_s = dy > dx;
    ma0     = steep_s ? y_start_i : x_start_i;
    na0     = steep_s ? x_start_i : y_start_i;
    mb0     = steep_s ? y_end_i   : x_end_i;
    nb0     = steep_s ? x_end_i   : y_end_i;
    swap_s  = ma0 > mb0;
    ma      = swap_s ? mb0 : ma0;
    na      = swap_s ? nb0 : na0;
    mb      = swap_s ? ma0 : mb0;
    nb      = swap_s ? na0 : nb0;
    s_major_delta = mb - ma;
  end

  assign err_sub = error_acc_q - signed'({2'b00, minor_delta_q});
  assign is_last = major_pos_q == major_end_q;

  always_comb begin
    busy_d        = busy_q;
    major_pos_d   = major_pos_q;
    minor_pos_d   = minor_pos_q;
    major_end_d   = major_end_q;
    major_delta_d = major_delta_q;
    minor_delta_d = minor_delta_q;
    error_acc_d   = error_acc_q;
    minor_down_d  = minor_down_q;
    steep_d       = steep_q;
    page_d        = page_q;
    if (exec_i) begin
      if (req_type_i == REQ_START) begin
        busy_d        = 1'b1;
        steep_d       = steep_s;
        major_pos_d   = ma;
        minor_pos_d   = na;
        major_end_d   = mb;
        major_delta_d = s_major_delta;
        minor_delta_d = (na > nb) ? na - nb : nb - na;
        error_acc_d   = signed'({3'b000, s_major_delta[COORD_W-1:1]});
        minor_down_d  = !(na < nb);
        page_d        = page_sel_i;
      end else if (busy_q) begin
        error_acc_d = err_sub;
        if (err_sub < 0) begin
          minor_pos_d = minor_down_q ? minor_pos_q - 1'b1 : minor_pos_q + 1'b1;
          error_acc_d = err_sub + signed'({2'b00, major_delta_q});
        end
        major_pos_d = major_pos_q + 1'b1;
        if (is_last) begin
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      major_pos_q   <= '0;
      minor_pos_q   <= '0;
      major_end_q   <= '0;
      major_delta_q <= '0;
      minor_delta_q <= '0;
      error_acc_q   <= '0;
      minor_down_q  <= 1'b0;
      steep_q       <= 1'b0;
      page_q        <= '0;
    end else begin
      busy_q        <= busy_d;
      major_pos_q   <= major_pos_d;
      minor_pos_q   <= minor_pos_d;
      major_end_q   <= major_end_d;
      major_delta_q <= major_delta_d;
      minor_delta_q <= minor_delta_d;
      error_acc_q   <= error_acc_d;
      minor_down_q  <= minor_down_d;
      steep_q       <= steep_d;
      page_q        <= page_d;
    end
  end

  always_comb begin
    pixel_o.valid = exec_i && (req_type_i == REQ_STEP) && busy_q;
    pixel_o.x     = steep_q ? minor_pos_q : major_pos_q;
    pixel_o.y     = steep_q ? major_pos_q : minor_pos_q;
    pixel_o.page  = page_q;
    pixel_o.last  = is_last;
  end

  // The final pixel of a line always ends it.
  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_o.valid && pixel_o.last) |=> !busy_q)
    else $error("line still busy after its last pixel");

  // The error term stays within [0, major_delta), or at zero, while a line is drawn.
  a_error_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (!error_acc_q[ERR_W-1] &&
                ((error_acc_q[ERR_W-2:0] < {1'b0, major_delta_q}) ||
                 (error_acc_q == '0))))
    else $error("error accumulator out of range");

endmodule

>>> rtl/core/blpe_addr.sv
module blpe_addr #(
  parameter int unsigned PAGE_BYTES = 8192
) (
  input  blpe_pkg::blpe_pixel_t        pixel_i,
  output logic [blpe_pkg::ADDR_W-1:0]  byte_address_o,
  output logic [blpe_pkg::MASK_W-1:0]  bit_mask_o,
  output logic                         write_enable_o
);
  import blpe_pkg::*;

  localparam int unsigned StoreBytes = 4 * PAGE_BYTES;
  // Wide enough for eight times the store, the largest multiple subtracted.
  localparam int unsigned ModW = 20;
  // The raw address never reaches sixteen store sizes, so four halving steps reduce it.
  localparam int unsigned ModSteps = 4;

  logic [ModW-1:0] raw_addr;
  logic [ModW-1:0] red_addr;

  assign raw_addr = ModW'(pixel_i.page) * ModW'(PAGE_BYTES)
                  + (ModW'(pixel_i.y) << LINE_SHIFT)
                  + ModW'(pixel_i.x[COORD_W-1:BYTE_SHIFT]);

  always_comb begin
    red_addr = raw_addr;
    for (int k = ModSteps - 1; k >= 0; k--) begin
      if (red_addr >= ModW'(StoreBytes << k)) begin
        red_addr = red_addr - ModW'(StoreBytes << k);
      end
    end
  end

  assign byte_address_o = red_addr[ADDR_W-1:0];
  assign bit_mask_o     = MASK_MSB >> pixel_i.x[BYTE_SHIFT-1:0];
  assign write_enable_o = pixel_i.x[COORD_W-1:BYTE_SHIFT] < COL_W'(LINE_BYTES);

endmodule
